### sv/dlt_pkg.sv
// dlt_pkg: shared sizes and types for the destination lru table
// table geometry, entry layout and result item; no dependencies
package dlt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = 4;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic [31:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              reject;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       use_count;
  } result_t;

endpackage

### sv/dlt_ram.sv
// dlt_ram: generic single write, single read synchronous ram
// read data registered; no dependencies
module dlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/dlt_ctrl.sv
// dlt_ctrl: scan sequencer, victim tracking, expiry decision and write-back
// depends on dlt_pkg; drives the table ram and the result registers
module dlt_ctrl import dlt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        dest_address,
  input  logic [31:0]        now_seconds,
  input  logic signed [31:0] expiration,
  output logic               busy,
  output logic               done,
  output result_t            res,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output logic [IDX_W-1:0]   mem_raddr,
  input  logic [ENTRY_W-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   cmp_idx;
  logic [31:0]        addr_q;
  logic [31:0]        now_q;
  logic [ENTRIES-1:0] valid;
  logic               have_empty;
  logic               have_any;
  logic [IDX_W-1:0]   victim;
  logic [31:0]        vtime;

  entry_t e;
  logic   match;
  logic   expired;
  logic   last_idx;
  entry_t wentry;

  always_comb begin
    e        = valid[cmp_idx] ? entry_t'(mem_rdata) : '0;
    match    = (e.address == addr_q);
    expired  = (({1'b0, vtime} + {1'b0, $unsigned(expiration)}) < {1'b0, now_q});
    last_idx = (cmp_idx == IDX_W'(ENTRIES - 1));
    busy     = (state != S_IDLE);
    mem_raddr = (state == S_SCAN) ? cmp_idx + IDX_W'(1) : '0;
    mem_we    = 1'b0;
    mem_waddr = cmp_idx;
    wentry    = e;
    case (state)
      S_SCAN: begin
        mem_we           = match;
        wentry.last_time = now_q;
        wentry.count     = e.count + 32'd1;
      end
      S_DECIDE: begin
        mem_we            = expired;
        mem_waddr         = victim;
        wentry.address    = addr_q;
        wentry.first_time = now_q;
        wentry.last_time  = now_q;
        wentry.count      = 32'd1;
      end
      default: begin
      end
    endcase
    mem_wdata = ENTRY_W'(wentry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      if (mem_we) begin
        valid[mem_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (expiration[31]) begin
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (last_idx) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        addr_q     <= dest_address;
        now_q      <= now_seconds;
        cmp_idx    <= '0;
        have_empty <= 1'b0;
        have_any   <= 1'b0;
        victim     <= '0;
        vtime      <= '0;
        res        <= '0;
      end
      S_SCAN: begin
        cmp_idx <= cmp_idx + IDX_W'(1);
        if (match) begin
          res.reject    <= 1'b0;
          res.hit       <= 1'b1;
          res.slot      <= SLOT_W'(cmp_idx);
          res.use_count <= wentry.count;
        end else if (e.address == 32'd0) begin
          if (!have_empty) begin
            have_empty <= 1'b1;
            victim     <= cmp_idx;
            vtime      <= '0;
          end
        end else if (!have_empty && (!have_any || e.last_time < vtime)) begin
          have_any <= 1'b1;
          victim   <= cmp_idx;
          vtime    <= e.last_time;
        end
      end
      S_DECIDE: begin
        res.reject    <= !expired;
        res.hit       <= 1'b0;
        res.slot      <= SLOT_W'(victim);
        res.use_count <= expired ? 32'd1 : 32'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/destination_lru_table_top.sv
// destination_lru_table_top: top level of the destination lru table
// holds the expiry register; uses dlt_pkg, dlt_ctrl and dlt_ram
//
// An item is taken when start is high and busy is low. The table lives in one
// synchronous ram read one entry a cycle, so a hit returns its result once the
// scan reaches its entry, and a miss once the whole table is scanned and the
// victim decided. With a negative expiration the result follows in the cycle
// after the item and busy stays low. The result is shown for one cycle under
// done and cannot be held off; busy is low again in that cycle, so the next
// item may be taken while the result is on the ports. The table is empty
// straight after reset, with no clearing pass.
module destination_lru_table_top import dlt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        dest_address,
  input  logic [31:0]        now_seconds,
  output logic               done,
  output logic               reject,
  output logic               hit,
  output logic [SLOT_W-1:0]  slot,
  output logic [31:0]        use_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] expiration_seconds
);

  logic signed [31:0] expiration;
  result_t            res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiration <= -32'sd1;
    end else if (cfg_valid && cfg_ready) begin
      expiration <= expiration_seconds;
    end
  end

  dlt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .dest_address (dest_address),
    .now_seconds  (now_seconds),
    .expiration   (expiration),
    .busy         (busy),
    .done         (done),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  dlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign reject    = res.reject;
  assign hit       = res.hit;
  assign slot      = res.slot;
  assign use_count = res.use_count;

  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(reject && hit))
    else $error("reject and hit together");

  a_rej_count: assert property (@(posedge clk) disable iff (rst)
    done && reject |-> use_count == 32'd0)
    else $error("rejected item with nonzero count");

  a_off: assert property (@(posedge clk) disable iff (rst)
    start && !busy && expiration[31] |=> done && !busy && !hit && !reject)
    else $error("disabled item not passed at once");

  a_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item lost");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !mem_we)
    else $error("table write while idle");

endmodule

### tb/testbench.sv
// testbench: self-checking bench for destination_lru_table_top
// runs directed then random requests through a queued driver and a monitor,
// predicting each result in step with the bench's own copy of the table
// depends on dlt_pkg and destination_lru_table_top
module testbench;
  import dlt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 22;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 100;
  localparam logic signed [31:0] WINDOW_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WINDOW_OFF = -32'sd1;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] at;
  } request_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [31:0]       dest_address = '0;
  logic [31:0]       now_seconds = '0;
  logic              done;
  logic              reject;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       use_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic signed [31:0] expiration_seconds = '0;

  request_t pending_requests[$];
  result_t  expected_verdicts[$];

  logic [31:0]        tab_addr[ENTRIES];
  logic [31:0]        tab_first[ENTRIES];
  logic [31:0]        tab_last[ENTRIES];
  logic [31:0]        tab_count[ENTRIES];
  logic signed [31:0] window_model = WINDOW_OFF;

  bit taken;
  bit steady;
  int fail_count;
  int cycle_count;

  destination_lru_table_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .dest_address(dest_address),
    .now_seconds(now_seconds),
    .done(done),
    .reject(reject),
    .hit(hit),
    .slot(slot),
    .use_count(use_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .expiration_seconds(expiration_seconds)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic predict_lookup(input logic [31:0] addr, input logic [31:0] at,
                                output result_t res);
    int victim;
    logic [31:0] victim_last;
    bit have_empty;
    bit have_any;
    bit found;
    res = '0;
    victim = 0;
    victim_last = '0;
    have_empty = 0;
    have_any = 0;
    found = 0;
    if (window_model[31]) return;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found) begin
        if (tab_addr[i] == addr) begin
          found = 1;
          tab_last[i] = at;
          tab_count[i] = tab_count[i] + 32'd1;
          res.hit = 1'b1;
          res.slot = i[SLOT_W-1:0];
          res.use_count = tab_count[i];
        end else if (tab_addr[i] == '0) begin
          if (!have_empty) begin
            have_empty = 1;
            victim = i;
            victim_last = '0;
          end
        end else if (!have_empty && (!have_any || tab_last[i] < victim_last)) begin
          have_any = 1;
          victim = i;
          victim_last = tab_last[i];
        end
      end
    end
    if (!found) begin
      res.slot = victim[SLOT_W-1:0];
      // sum kept one bit wider so it cannot wrap
      if ({1'b0, victim_last} + {1'b0, window_model} < {1'b0, at}) begin
        tab_addr[victim] = addr;
        tab_first[victim] = at;
        tab_last[victim] = at;
        tab_count[victim] = 32'd1;
        res.use_count = 32'd1;
      end else begin
        res.reject = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // driver: a raised start is held until the item is taken
  always @(negedge clk) begin
    if (!start || taken) begin
      if (pending_requests.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
        start <= 1'b1;
        dest_address <= pending_requests[0].addr;
        now_seconds <= pending_requests[0].at;
      end else begin
        start <= 1'b0;
        dest_address <= $urandom;
        now_seconds <= $urandom;
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    request_t req;
    taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("reject", 32'(want.reject), 32'(reject));
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("use_count", want.use_count, use_count);
        end
      end
      if (start && !busy) begin
        taken = 1'b1;
        req = pending_requests.pop_front();
        predict_lookup(dest_address, now_seconds, want);
        expected_verdicts.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("destination_lru_table_top test failed");
      $finish;
    end
  end

  task automatic queue_request(input logic [31:0] addr, input logic [31:0] at);
    request_t req;
    req.addr = addr;
    req.at = at;
    pending_requests.push_back(req);
  endtask

  task automatic set_window(input logic signed [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    expiration_seconds <= value;
    do @(posedge clk); while (!cfg_ready);
    window_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    expiration_seconds <= $urandom;
  endtask

  task automatic drain;
    while (pending_requests.size() > 0 || expected_verdicts.size() > 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] pool[POOL_SIZE];
    logic signed [31:0] windows[NUM_PHASES];
    logic [31:0] clock_now;
    logic [31:0] addr;
    logic [31:0] at;
    int pick;
    for (int i = 0; i < ENTRIES; i++) begin
      tab_addr[i] = '0;
      tab_first[i] = '0;
      tab_last[i] = '0;
      tab_count[i] = '0;
    end
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'hffff_ffff;
    windows = '{32'sd20, 32'sd3, WINDOW_MAX, WINDOW_OFF, 32'sd60, 32'sd0};
    steady = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled straight after reset
    queue_request(32'h0, 32'h0);
    queue_request(32'hffff_ffff, 32'hffff_ffff);
    drain();

    // zero window: address zero, reject at equal time, fill, ties
    set_window(32'sd0);
    queue_request(32'h0, 32'd5);
    queue_request(32'h0, 32'd6);
    queue_request(32'h0a00_0001, 32'd0);
    queue_request(32'h0a00_0001, 32'd1);
    queue_request(32'h0a00_0001, 32'd1);
    for (int k = 1; k < ENTRIES; k++) queue_request(32'hffff_ffff - 32'(ENTRIES - 1 - k), 32'd20);
    queue_request(32'h0, 32'd21);
    queue_request(32'h8000_0000, 32'd21);
    queue_request(32'h1234_5678, 32'd20);
    drain();

    clock_now = 32'd30;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_window(windows[p]);
      steady = (p == 0);
      if (windows[p] == WINDOW_MAX) clock_now = 32'hffff_ff00;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) addr = $urandom;
        else if (pick < 12) addr = '0;
        else addr = pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(99) < 5) begin
          at = $urandom;
        end else begin
          clock_now = clock_now + 32'($urandom_range(3));
          at = clock_now;
        end
        queue_request(addr, at);
      end
      drain();
    end
    steady = 0;

    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("destination_lru_table_top test passed");
    end else begin
      $display("destination_lru_table_top test failed");
    end
    $finish;
  end

endmodule
